// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while reset is released.
`define NFA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("nfa assertion failed");
// Checked at every edge, reset included.
`define NFA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("nfa assertion failed");
`else
`define NFA_ASSERT(lbl, clk, rst_n, prop)
`define NFA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/nfa_pkg.sv =====
// Types and constants of the node fit allocator.
package nfa_pkg;

  localparam int unsigned NODE_COUNT_DEF = 128;

  localparam logic [7:0]  RST_CORES  = 8'd24;
  localparam logic [7:0]  RST_MEMORY = 8'd64;
  localparam logic [14:0] SUM_MAX    = 15'h7fff;
  localparam logic [15:0] COUNT_MAX  = 16'hffff;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_policy_e;

  typedef enum logic [1:0] {
    REG_FIT_POLICY = 2'd0,
    REG_CORE_CAP   = 2'd1,
    REG_MEM_CAP    = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_FINISH
  } state_e;

endpackage

// ===== rtl/node_fit_allocator_top.sv =====
// Node fit allocator: node table in one memory, scanned once per allocate job.
//
//   channel | direction | word
//   in      | sink      | cmd_i, cores_required_i, memory_required_i
//   out     | source    | granted_o, node_index_o, totals, jobs_placed_o
//   cfg     | sink      | cfg_index_i, cfg_data_i (always ready)
//
// Allocate: the single read port of the node memory walks every entry
// once, one per cycle. Clear: one memory write per entry.
// After reset a fill sweep loads 24 cores / 64 memory into every node;
// in_ready_o stays low until it ends.
// A result waiting on out_ready_i does not block accepting the next word;
// the finish step waits only if the output register is still full.
`include "assert_macros.svh"

module node_fit_allocator_top #(
  parameter int unsigned NODE_COUNT = nfa_pkg::NODE_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  cores_required_i,
  input  logic [7:0]  memory_required_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        granted_o,
  output logic [6:0]  node_index_o,
  output logic [14:0] total_cores_used_o,
  output logic [14:0] total_memory_used_o,
  output logic [15:0] jobs_placed_o
);

  localparam int unsigned AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned CW = $clog2(NODE_COUNT + 1);
  localparam logic [CW-1:0] CNT_END  = CW'(NODE_COUNT);
  localparam logic [CW-1:0] CNT_LAST = CW'(NODE_COUNT - 1);

  // config registers
  logic [1:0] policy_q;
  logic [7:0] core_cap_q, mem_cap_q;

  // control
  nfa_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q;
  logic            rdv_q;
  logic [AW-1:0]   ridx_q;

  // job word
  logic       cmd_q;
  logic [7:0] need_c_q, need_m_q;

  // current choice
  logic          found_q;
  logic [AW-1:0] pick_q;
  logic [7:0]    pc_q, pm_q;

  // totals
  logic [14:0] csum_q, msum_q, csum_d, msum_d;
  logic [15:0] jobs_q, jobs_d;
  logic [15:0] csum_ext, msum_ext;

  // memory: {free cores, free memory}
  logic [15:0]   mem_q [NODE_COUNT];
  logic [15:0]   rd_data_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;

  // output register
  logic        out_vld_q;
  logic        granted_q;
  logic [6:0]  nidx_q;
  logic [14:0] ocsum_q, omsum_q;
  logic [15:0] ojobs_q;

  logic in_acc, out_load, scan_issue, scan_done, take;
  logic [7:0] fc, fm;
  logic elig, better, worse;

  assign cfg_ready_o = 1'b1;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q   <= nfa_pkg::FIT_FIRST;
      core_cap_q <= nfa_pkg::RST_CORES;
      mem_cap_q  <= nfa_pkg::RST_MEMORY;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        nfa_pkg::REG_FIT_POLICY: policy_q   <= cfg_data_i[1:0];
        nfa_pkg::REG_CORE_CAP:   core_cap_q <= cfg_data_i;
        nfa_pkg::REG_MEM_CAP:    mem_cap_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // scan evaluation on the word read last cycle
  assign fc     = rd_data_q[15:8];
  assign fm     = rd_data_q[7:0];
  assign elig   = (fc >= need_c_q) && (fm >= need_m_q) &&
                  ((policy_q == nfa_pkg::FIT_FIRST) || (policy_q == nfa_pkg::FIT_BEST) ||
                   (policy_q == nfa_pkg::FIT_WORST));
  assign better = (policy_q == nfa_pkg::FIT_BEST)  && (fc < pc_q) && (fm < pm_q);
  assign worse  = (policy_q == nfa_pkg::FIT_WORST) && (fc > pc_q) && (fm > pm_q);
  assign take   = rdv_q && elig && (!found_q || better || worse);

  assign scan_issue = (state_q == nfa_pkg::ST_SCAN) && (cnt_q != CNT_END);
  assign scan_done  = (state_q == nfa_pkg::ST_SCAN) && (cnt_q == CNT_END) && !rdv_q;

  // saturating totals for the finish step
  assign csum_ext = {1'b0, csum_q} + 16'(need_c_q);
  assign msum_ext = {1'b0, msum_q} + 16'(need_m_q);
  always_comb begin
    csum_d = csum_q;
    msum_d = msum_q;
    jobs_d = jobs_q;
    if (cmd_q == nfa_pkg::CMD_CLEAR) begin
      csum_d = '0;
      msum_d = '0;
      jobs_d = '0;
    end else if (found_q) begin
      csum_d = csum_ext[15] ? nfa_pkg::SUM_MAX : csum_ext[14:0];
      msum_d = msum_ext[15] ? nfa_pkg::SUM_MAX : msum_ext[14:0];
      jobs_d = (jobs_q == nfa_pkg::COUNT_MAX) ? jobs_q : jobs_q + 16'd1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nfa_pkg::ST_INIT:   if (cnt_q == CNT_LAST) state_d = nfa_pkg::ST_IDLE;
      nfa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (cmd_i == nfa_pkg::CMD_CLEAR) ? nfa_pkg::ST_FILL : nfa_pkg::ST_SCAN;
        end
      end
      nfa_pkg::ST_SCAN:   if (scan_done) state_d = nfa_pkg::ST_FINISH;
      nfa_pkg::ST_FILL:   if (cnt_q == CNT_LAST) state_d = nfa_pkg::ST_FINISH;
      nfa_pkg::ST_FINISH: if (!out_vld_q || out_ready_i) state_d = nfa_pkg::ST_IDLE;
      default:            state_d = nfa_pkg::ST_IDLE;
    endcase
  end

  // state outputs: handshake and memory write port
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cnt_q[AW-1:0];
    mem_wdata  = {core_cap_q, mem_cap_q};
    case (state_q)
      nfa_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {nfa_pkg::RST_CORES, nfa_pkg::RST_MEMORY};
      end
      nfa_pkg::ST_IDLE: in_ready_o = 1'b1;
      nfa_pkg::ST_FILL: mem_we = 1'b1;
      nfa_pkg::ST_FINISH: begin
        out_load  = !out_vld_q || out_ready_i;
        mem_we    = out_load && found_q;
        mem_waddr = pick_q;
        mem_wdata = {pc_q - need_c_q, pm_q - need_m_q};
      end
      default: ;
    endcase
  end

  assign in_acc = in_valid_i && in_ready_o;

  // node memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[cnt_q[AW-1:0]];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nfa_pkg::ST_INIT;
      cnt_q   <= '0;
      rdv_q   <= 1'b0;
      found_q <= 1'b0;
      csum_q  <= '0;
      msum_q  <= '0;
      jobs_q  <= '0;
    end else begin
      state_q <= state_d;
      rdv_q   <= scan_issue;
      if (in_acc) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else if (scan_issue || state_q == nfa_pkg::ST_INIT ||
                   state_q == nfa_pkg::ST_FILL) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (take) found_q <= 1'b1;
      if (out_load) begin
        csum_q <= csum_d;
        msum_q <= msum_d;
        jobs_q <= jobs_d;
      end
    end
  end

  // job word and running choice
  always_ff @(posedge clk_i) begin
    ridx_q <= cnt_q[AW-1:0];
    if (in_acc) begin
      cmd_q    <= cmd_i;
      need_c_q <= cores_required_i;
      need_m_q <= memory_required_i;
    end
    if (take) begin
      pick_q <= ridx_q;
      pc_q   <= fc;
      pm_q   <= fm;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      granted_q <= found_q && (cmd_q == nfa_pkg::CMD_ALLOC);
      nidx_q    <= (found_q && (cmd_q == nfa_pkg::CMD_ALLOC)) ? 7'(pick_q) : 7'd0;
      ocsum_q   <= csum_d;
      omsum_q   <= msum_d;
      ojobs_q   <= jobs_d;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign granted_o           = granted_q;
  assign node_index_o        = nidx_q;
  assign total_cores_used_o  = ocsum_q;
  assign total_memory_used_o = omsum_q;
  assign jobs_placed_o       = ojobs_q;

  // no node write while the scan is reading the table
  `NFA_ASSERT(a_no_write_in_scan, clk_i, rst_ni, (state_q == nfa_pkg::ST_SCAN) |-> !mem_we)
  // a held choice always names a real node
  `NFA_ASSERT(a_pick_in_range, clk_i, rst_ni, found_q |-> (32'(pick_q) < NODE_COUNT))
  // a granted result always comes with a nonzero placed count
  `NFA_ASSERT(a_grant_counted, clk_i, rst_ni, (out_vld_q && granted_q) |-> (ojobs_q != 16'd0))
  // no read word in flight while a new job can be taken
  `NFA_ASSERT_ALWAYS(a_idle_no_read, clk_i, in_ready_o |-> !rdv_q)

endmodule

// ===== tb/sv/nfa_placement_check.sv =====
// Checker for the node fit allocator: mirrors the node table and compares each result word.
module nfa_placement_check #(
  parameter int unsigned NODE_COUNT = nfa_pkg::NODE_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  cores_required_i,
  input  logic [7:0]  memory_required_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic        granted_o,
  input  logic [6:0]  node_index_o,
  input  logic [14:0] total_cores_used_o,
  input  logic [14:0] total_memory_used_o,
  input  logic [15:0] jobs_placed_o,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        granted;
    logic [6:0]  node;
    logic [14:0] cores_used;
    logic [14:0] mem_used;
    logic [15:0] jobs;
  } placement_t;

  // shadow copy of the node table, totals and registers
  logic [1:0]  fit_rule;
  logic [7:0]  core_fill;
  logic [7:0]  mem_fill;
  logic [7:0]  avail_cores [NODE_COUNT];
  logic [7:0]  avail_mem   [NODE_COUNT];
  logic [14:0] cores_total;
  logic [14:0] mem_total;
  logic [15:0] jobs_total;

  placement_t  expected_placements [$];
  int unsigned mismatches    = 0;
  int unsigned pending_words = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_words;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t nfa_check: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void refill(logic [7:0] cores, logic [7:0] mem);
    for (int i = 0; i < NODE_COUNT; i++) begin
      avail_cores[i] = cores;
      avail_mem[i]   = mem;
    end
  endfunction

  // Scan in index order; best/worst only move the choice on a strict win in both resources.
  function automatic placement_t predict_placement(logic op, logic [7:0] need_c,
                                                   logic [7:0] need_m);
    placement_t res;
    logic       found;
    logic       rule_known;
    int         pick;
    int         sum;
    found      = 1'b0;
    pick       = 0;
    rule_known = (fit_rule == nfa_pkg::FIT_FIRST) || (fit_rule == nfa_pkg::FIT_BEST) ||
                 (fit_rule == nfa_pkg::FIT_WORST);
    if (op == nfa_pkg::CMD_CLEAR) begin
      refill(core_fill, mem_fill);
      cores_total = '0;
      mem_total   = '0;
      jobs_total  = '0;
    end else if (rule_known) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        if (avail_cores[i] >= need_c && avail_mem[i] >= need_m) begin
          if (!found) begin
            found = 1'b1;
            pick  = i;
          end else if (fit_rule == nfa_pkg::FIT_BEST && avail_cores[i] < avail_cores[pick] &&
                       avail_mem[i] < avail_mem[pick]) begin
            pick = i;
          end else if (fit_rule == nfa_pkg::FIT_WORST && avail_cores[i] > avail_cores[pick] &&
                       avail_mem[i] > avail_mem[pick]) begin
            pick = i;
          end
        end
      end
      if (found) begin
        avail_cores[pick] = avail_cores[pick] - need_c;
        avail_mem[pick]   = avail_mem[pick] - need_m;
        sum         = cores_total + need_c;
        cores_total = (sum > nfa_pkg::SUM_MAX) ? nfa_pkg::SUM_MAX : sum[14:0];
        sum         = mem_total + need_m;
        mem_total   = (sum > nfa_pkg::SUM_MAX) ? nfa_pkg::SUM_MAX : sum[14:0];
        sum         = jobs_total + 1;
        jobs_total  = (sum > nfa_pkg::COUNT_MAX) ? nfa_pkg::COUNT_MAX : sum[15:0];
      end
    end
    res.granted    = found;
    res.node       = found ? 7'(pick) : '0;
    res.cores_used = cores_total;
    res.mem_used   = mem_total;
    res.jobs       = jobs_total;
    return res;
  endfunction

  // watch the three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    placement_t want;
    if (!rst_ni) begin
      fit_rule    = nfa_pkg::FIT_FIRST;
      core_fill   = nfa_pkg::RST_CORES;
      mem_fill    = nfa_pkg::RST_MEMORY;
      refill(nfa_pkg::RST_CORES, nfa_pkg::RST_MEMORY);
      cores_total = '0;
      mem_total   = '0;
      jobs_total  = '0;
      expected_placements.delete();
      pending_words = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          nfa_pkg::REG_FIT_POLICY: fit_rule  = cfg_data_i[1:0];
          nfa_pkg::REG_CORE_CAP:   core_fill = cfg_data_i;
          nfa_pkg::REG_MEM_CAP:    mem_fill  = cfg_data_i;
          default: ;
        endcase
      end
      // append the prediction at the tail
      if (in_valid_i && in_ready_o) begin
        expected_placements = {expected_placements,
          predict_placement(cmd_i, cores_required_i, memory_required_i)};
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_placements.size() == 0) begin
          report_mismatch("result word with nothing expected, node", 32'(node_index_o), 0);
        end else begin
          want = expected_placements.pop_front();
          if (granted_o !== want.granted)
            report_mismatch("granted", 32'(granted_o), 32'(want.granted));
          if (node_index_o !== want.node)
            report_mismatch("node_index", 32'(node_index_o), 32'(want.node));
          if (total_cores_used_o !== want.cores_used)
            report_mismatch("total_cores_used", 32'(total_cores_used_o),
                            32'(want.cores_used));
          if (total_memory_used_o !== want.mem_used)
            report_mismatch("total_memory_used", 32'(total_memory_used_o),
                            32'(want.mem_used));
          if (jobs_placed_o !== want.jobs)
            report_mismatch("jobs_placed", 32'(jobs_placed_o), 32'(want.jobs));
        end
      end
      pending_words = expected_placements.size();
    end
  end

endmodule

// ===== tb/sv/tb_node_fit_allocator_top.sv =====
// Testbench top for the node fit allocator: stimulus, flow control, watchdog and verdict.
module tb_node_fit_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NODES          = nfa_pkg::NODE_COUNT_DEF;
  localparam logic [1:0]  FIT_UNUSED     = 2'd3;
  localparam logic [1:0]  REG_UNUSED     = 2'd3;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned QUIET_LIMIT    = 4000;
  localparam int unsigned RANDOM_PHASES  = 12;
  localparam int unsigned JOBS_PER_PHASE = 130;
  localparam int unsigned CLEAR_PCT      = 3;

  logic          clk_i             = 1'b0;
  logic          rst_ni            = 1'b0;
  logic          cfg_valid_i       = 1'b0;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i       = '0;
  logic [7:0]    cfg_data_i        = '0;
  logic          in_valid_i        = 1'b0;
  logic          in_ready_o;
  nfa_pkg::cmd_e cmd_i             = nfa_pkg::CMD_ALLOC;
  logic [7:0]    cores_required_i  = '0;
  logic [7:0]    memory_required_i = '0;
  logic          out_valid_o;
  logic          out_ready_i       = 1'b0;
  logic          granted_o;
  logic [6:0]    node_index_o;
  logic [14:0]   total_cores_used_o;
  logic [14:0]   total_memory_used_o;
  logic [15:0]   jobs_placed_o;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned quiet_cycles  = 0;
  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_stall_pct = 0;

  always #10 clk_i = ~clk_i;

  node_fit_allocator_top #(
    .NODE_COUNT(NODES)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cmd_i              (cmd_i),
    .cores_required_i   (cores_required_i),
    .memory_required_i  (memory_required_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .granted_o          (granted_o),
    .node_index_o       (node_index_o),
    .total_cores_used_o (total_cores_used_o),
    .total_memory_used_o(total_memory_used_o),
    .jobs_placed_o      (jobs_placed_o)
  );

  nfa_placement_check #(
    .NODE_COUNT(NODES)
  ) u_placement_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cmd_i              (cmd_i),
    .cores_required_i   (cores_required_i),
    .memory_required_i  (memory_required_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .granted_o          (granted_o),
    .node_index_o       (node_index_o),
    .total_cores_used_o (total_cores_used_o),
    .total_memory_used_o(total_memory_used_o),
    .jobs_placed_o      (jobs_placed_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending_words)
  );

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // watchdog: cycles without any accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("tb_node_fit_allocator_top: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // 0: no idling, 1: sender idle, 2: receiver stalls, 3: both, lightly
  task automatic set_idle_mode(input int unsigned mode);
    case (mode)
      1:       begin snd_idle_pct = 83; rcv_stall_pct = 0;  end
      2:       begin snd_idle_pct = 0;  rcv_stall_pct = 83; end
      3:       begin snd_idle_pct = 28; rcv_stall_pct = 28; end
      default: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
    endcase
  endtask

  // valid stays high across back-to-back words; it only drops on an idle cycle or in wait_drained
  task automatic send_word(input nfa_pkg::cmd_e op, input logic [7:0] need_c,
                           input logic [7:0] need_m);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    cmd_i             <= op;
    cores_required_i  <= need_c;
    memory_required_i <= need_m;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop sending and let every outstanding result drain
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_words != 0);
    @(posedge clk_i);
  endtask

  // mix of zero, full-range, near-capacity and small demands
  function automatic logic [7:0] pick_demand(input logic [7:0] cap);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8)  return '0;
    if (r < 16) return 8'($urandom_range(255));
    if (r < 50) return 8'($urandom_range(cap, cap / 2));
    return 8'($urandom_range(cap / 3 + 1, 0));
  endfunction

  initial begin
    logic [1:0] rule;
    logic [7:0] core_cap;
    logic [7:0] mem_cap;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    // wait for the fill sweep after reset
    do @(posedge clk_i); while (!in_ready_o);

    // directed: reset config, first fit, nodes at 24 cores / 64 memory
    set_idle_mode(0);
    send_word(nfa_pkg::CMD_ALLOC, 8'd0, 8'd0);       // zero demand lands on node 0
    send_word(nfa_pkg::CMD_ALLOC, 8'd24, 8'd64);     // exact fit empties node 0
    send_word(nfa_pkg::CMD_ALLOC, 8'd25, 8'd0);      // too many cores everywhere
    send_word(nfa_pkg::CMD_ALLOC, 8'd0, 8'd65);      // too much memory everywhere
    send_word(nfa_pkg::CMD_ALLOC, 8'hff, 8'hff);
    send_word(nfa_pkg::CMD_ALLOC, 8'hff, 8'd0);
    wait_drained();
    write_reg(nfa_pkg::REG_FIT_POLICY, 8'(nfa_pkg::FIT_BEST));
    send_word(nfa_pkg::CMD_ALLOC, 8'd1, 8'd1);
    send_word(nfa_pkg::CMD_ALLOC, 8'd1, 8'd1);       // same node again, it is now the tightest
    send_word(nfa_pkg::CMD_ALLOC, 8'd0, 8'd0);       // empty node 0 still eligible for zero demand
    wait_drained();
    write_reg(nfa_pkg::REG_FIT_POLICY, 8'(nfa_pkg::FIT_WORST));
    send_word(nfa_pkg::CMD_ALLOC, 8'd2, 8'd2);
    send_word(nfa_pkg::CMD_ALLOC, 8'd0, 8'd0);
    wait_drained();
    write_reg(nfa_pkg::REG_FIT_POLICY, 8'(FIT_UNUSED));  // unused rule refuses everything
    send_word(nfa_pkg::CMD_ALLOC, 8'd0, 8'd0);
    wait_drained();
    write_reg(REG_UNUSED, 8'ha5);                    // no such register, ignored
    write_reg(nfa_pkg::REG_FIT_POLICY, 8'hfc);       // upper bits dropped: first fit
    write_reg(nfa_pkg::REG_CORE_CAP, 8'd1);
    write_reg(nfa_pkg::REG_MEM_CAP, 8'd255);
    send_word(nfa_pkg::CMD_ALLOC, 8'd24, 8'd64);     // old amounts kept until a clear
    send_word(nfa_pkg::CMD_CLEAR, 8'h5a, 8'ha5);
    send_word(nfa_pkg::CMD_ALLOC, 8'd1, 8'd255);
    send_word(nfa_pkg::CMD_ALLOC, 8'd1, 8'd0);
    send_word(nfa_pkg::CMD_ALLOC, 8'd0, 8'd1);
    send_word(nfa_pkg::CMD_ALLOC, 8'd2, 8'd0);
    wait_drained();
    write_reg(nfa_pkg::REG_CORE_CAP, 8'd255);
    write_reg(nfa_pkg::REG_MEM_CAP, 8'd255);
    write_reg(nfa_pkg::REG_FIT_POLICY, 8'(nfa_pkg::FIT_WORST));
    send_word(nfa_pkg::CMD_CLEAR, 8'd0, 8'd0);
    send_word(nfa_pkg::CMD_ALLOC, 8'd255, 8'd255);
    send_word(nfa_pkg::CMD_ALLOC, 8'd128, 8'd128);
    send_word(nfa_pkg::CMD_ALLOC, 8'd0, 8'd0);

    // random phases, each with its own rule, capacities and flow control
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      set_idle_mode(p % 4);
      rule = (p == 7) ? FIT_UNUSED : 2'(p % 3);
      case (p % 6)
        0:       begin core_cap = 8'd1;   mem_cap = 8'd1;   end
        1:       begin core_cap = 8'd255; mem_cap = 8'd255; end
        2:       begin core_cap = nfa_pkg::RST_CORES; mem_cap = nfa_pkg::RST_MEMORY; end
        3:       begin
          core_cap = 8'($urandom_range(16, 2));
          mem_cap  = 8'($urandom_range(16, 2));
        end
        4:       begin core_cap = 8'd255; mem_cap = 8'd1;   end
        default: begin core_cap = 8'd1;   mem_cap = 8'd255; end
      endcase
      write_reg(nfa_pkg::REG_FIT_POLICY, {6'($urandom), rule});
      write_reg(nfa_pkg::REG_CORE_CAP, core_cap);
      write_reg(nfa_pkg::REG_MEM_CAP, mem_cap);
      send_word(nfa_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom));
      for (int j = 0; j < JOBS_PER_PHASE; j++) begin
        if ($urandom_range(99) < CLEAR_PCT)
          send_word(nfa_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom));
        else
          send_word(nfa_pkg::CMD_ALLOC, pick_demand(core_cap), pick_demand(mem_cap));
      end
    end

    wait_drained();
    repeat (NODES + 16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_node_fit_allocator_top: PASS");
    end else begin
      $display("tb_node_fit_allocator_top: FAIL");
    end
    $finish;
  end

endmodule
